// ----- rtl/sfcr_pkg.sv -----
// Package for the SPI flash command responder: command codes, item kinds,
// reset constants and the array access command struct. No dependencies.
package sfcr_pkg;

    localparam logic [1:0] KIND_XFER = 2'd0;
    localparam logic [1:0] KIND_CS   = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    localparam logic [7:0] CMD_WREN      = 8'h06;
    localparam logic [7:0] CMD_WRDI      = 8'h04;
    localparam logic [7:0] CMD_RDID      = 8'h9F;
    localparam logic [7:0] CMD_READ      = 8'h03;
    localparam logic [7:0] CMD_FAST_READ = 8'h0B;
    localparam logic [7:0] CMD_DP        = 8'hB9;
    localparam logic [7:0] CMD_RES       = 8'hAB;

    localparam logic [23:0] JEDEC_RESET = 24'h205012;
    localparam logic [2:0]  COUNT_MAX   = 3'd7;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage

// ----- rtl/sfcr_array.sv -----
// Flash array storage: single-port synchronous memory with a registered read.
// Depends on sfcr_pkg for the access command struct.
module sfcr_array #(
    parameter int ARRAY_BYTES = 262144,
    parameter int ADDR_W      = 18
) (
    input  logic                  i_clk,
    input  sfcr_pkg::t_mem_cmd    i_cmd,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [7:0]            i_wdata,
    output logic [7:0]            o_rdata
);

    logic [7:0] r_mem [ARRAY_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sfcr_ctrl.sv -----
// Command decoder, protocol state and output register of the responder.
// Depends on sfcr_pkg; drives the array in sfcr_array.
module sfcr_ctrl #(
    parameter int ADDR_W = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_byte_value,
    input  logic [17:0]           i_load_address,
    input  logic                  i_cfg_wr_en,
    input  logic [23:0]           i_cfg_wr_data,
    output sfcr_pkg::t_mem_cmd    o_mem_cmd,
    output logic [ADDR_W-1:0]     o_mem_addr,
    output logic [7:0]            o_mem_wdata,
    input  logic [7:0]            i_mem_rdata,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_read_data,
    output logic                  o_write_enabled,
    output logic                  o_asleep
);

    typedef enum logic [2:0] {
        PH_CMD   = 3'd0,
        PH_IDLE  = 3'd1,
        PH_DEEP  = 3'd2,
        PH_ID    = 3'd3,
        PH_ADDR  = 3'd4,
        PH_ADDRF = 3'd5,
        PH_DUMMY = 3'd6,
        PH_READ  = 3'd7
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_latch, n_latch;
    logic [2:0]          r_count, n_count;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [23:0]         r_jedec;
    logic                r_valid;
    logic [7:0]          r_data, n_data;
    logic                r_from_mem, n_from_mem;
    logic                w_accept;
    sfcr_pkg::t_mem_cmd  w_cmd;
    logic [ADDR_W-1:0]   w_shift_addr;

    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_shift_addr = ADDR_W'({r_addr, i_byte_value});

    always_comb begin
        n_phase    = r_phase;
        n_latch    = r_latch;
        n_count    = r_count;
        n_addr     = r_addr;
        n_data     = 8'd0;
        n_from_mem = 1'b0;
        w_cmd      = '0;
        if (w_accept) begin
            unique case (i_kind)
                sfcr_pkg::KIND_XFER: begin
                    if (r_phase == PH_DEEP) begin
                        if (i_byte_value == sfcr_pkg::CMD_RES) begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_CMD: begin
                                unique case (i_byte_value)
                                    sfcr_pkg::CMD_WREN: begin
                                        n_latch = 1'b1;
                                        n_phase = PH_IDLE;
                                    end
                                    sfcr_pkg::CMD_WRDI: begin
                                        n_latch = 1'b0;
                                        n_phase = PH_IDLE;
                                    end
                                    sfcr_pkg::CMD_RDID:      n_phase = PH_ID;
                                    sfcr_pkg::CMD_READ:      n_phase = PH_ADDR;
                                    sfcr_pkg::CMD_FAST_READ: n_phase = PH_ADDRF;
                                    sfcr_pkg::CMD_DP:        n_phase = PH_DEEP;
                                    default: ;
                                endcase
                            end
                            PH_ADDR, PH_ADDRF: begin
                                if (r_count == 3'd1) begin
                                    n_addr = ADDR_W'(i_byte_value);
                                end else if (r_count == 3'd2 || r_count == 3'd3) begin
                                    n_addr = w_shift_addr;
                                end
                                if (r_count == 3'd3) begin
                                    n_phase = (r_phase == PH_ADDR) ? PH_READ : PH_DUMMY;
                                end
                            end
                            PH_DUMMY: n_phase = PH_READ;
                            PH_READ: begin
                                w_cmd.rd_en = 1'b1;
                                n_from_mem  = 1'b1;
                                n_addr      = r_addr + ADDR_W'(1);
                            end
                            PH_ID: begin
                                if (r_count == 3'd1) begin
                                    n_data = r_jedec[23:16];
                                end else if (r_count == 3'd2) begin
                                    n_data = r_jedec[15:8];
                                end else if (r_count == 3'd3) begin
                                    n_data  = r_jedec[7:0];
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: ;
                        endcase
                        if (r_count != sfcr_pkg::COUNT_MAX) begin
                            n_count = r_count + 3'd1;
                        end
                    end
                end
                sfcr_pkg::KIND_CS: begin
                    if (r_phase != PH_DEEP) begin
                        n_phase = PH_CMD;
                    end
                    n_count = 3'd0;
                end
                sfcr_pkg::KIND_LOAD: w_cmd.wr_en = 1'b1;
                default: ;
            endcase
        end
    end

    assign o_mem_cmd   = w_cmd;
    assign o_mem_addr  = w_cmd.wr_en ? ADDR_W'(i_load_address) : r_addr;
    assign o_mem_wdata = i_byte_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_latch    <= 1'b0;
            r_count    <= 3'd0;
            r_addr     <= '0;
            r_jedec    <= sfcr_pkg::JEDEC_RESET;
            r_valid    <= 1'b0;
            r_from_mem <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_jedec <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_phase    <= n_phase;
                r_latch    <= n_latch;
                r_count    <= n_count;
                r_addr     <= n_addr;
                r_valid    <= 1'b1;
                r_from_mem <= n_from_mem;
            end else if (!i_stall) begin
                r_valid    <= 1'b0;
                r_from_mem <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= n_data;
        end
    end

    assign o_valid         = r_valid;
    assign o_read_data     = r_from_mem ? i_mem_rdata : r_data;
    assign o_write_enabled = r_latch;
    assign o_asleep        = (r_phase == PH_DEEP);

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr_en && w_cmd.rd_en))
        else $error("array read and write in the same cycle");

    a_mem_word_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_from_mem |-> r_valid)
        else $error("array data selected without a valid word");

    a_asleep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_asleep) |-> (o_read_data == 8'd0))
        else $error("data returned while in deep power-down");

    a_deep_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DEEP && $past(r_phase) != PH_DEEP) |-> $past(r_phase) == PH_CMD)
        else $error("deep power-down entered outside command decode");

endmodule

// ----- rtl/spi_flash_command_responder.sv -----
// SPI flash command responder, slave side. Takes one word per cycle while the
// output is not stalled (SPI byte, chip-select release or array load) and
// returns one registered result word for each; a single register stage holds
// the result, and the next word is taken in the same cycle that result is
// taken, so a stalled result also stalls the input. The single-port array
// memory serves either one load or one streaming read per cycle.
// ARRAY_BYTES must be a power of two; addresses wrap modulo ARRAY_BYTES. The
// array is not cleared after reset: bytes must be loaded before being read.
// Depends on sfcr_pkg, sfcr_ctrl and sfcr_array.
module spi_flash_command_responder #(
    parameter int ARRAY_BYTES = 262144
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_byte_value,
    input  logic [17:0] i_load_address,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_write_enabled,
    output logic        o_asleep
);

    localparam int ADDR_W = $clog2(ARRAY_BYTES);

    sfcr_pkg::t_mem_cmd  w_mem_cmd;
    logic [ADDR_W-1:0]   w_mem_addr;
    logic [7:0]          w_mem_wdata;
    logic [7:0]          w_mem_rdata;

    sfcr_ctrl #(
        .ADDR_W(ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_byte_value   (i_byte_value),
        .i_load_address (i_load_address),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_mem_cmd      (w_mem_cmd),
        .o_mem_addr     (w_mem_addr),
        .o_mem_wdata    (w_mem_wdata),
        .i_mem_rdata    (w_mem_rdata),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_write_enabled(o_write_enabled),
        .o_asleep       (o_asleep)
    );

    sfcr_array #(
        .ARRAY_BYTES(ARRAY_BYTES),
        .ADDR_W     (ADDR_W)
    ) u_array (
        .i_clk  (i_clk),
        .i_cmd  (w_mem_cmd),
        .i_addr (w_mem_addr),
        .i_wdata(w_mem_wdata),
        .o_rdata(w_mem_rdata)
    );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for spi_flash_command_responder: random SPI command sequences,
// array loads and noise words, checked against a behavioral model.
// Depends on sfcr_pkg and the RTL of the responder.
module tb_top;

    localparam int          ARRAY_BYTES = 262144;
    localparam int          HOLD_CYCLES = 200;
    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [1:0]  KIND_RSVD   = 2'd3;

    typedef enum logic [2:0] {
        ST_CMD, ST_IDLE, ST_DEEP, ST_ID, ST_ADDR, ST_ADDR_FAST, ST_DUMMY, ST_STREAM
    } t_flash_phase;

    typedef struct packed {
        logic [7:0] read_data;
        logic       write_enabled;
        logic       asleep;
    } t_flash_resp;

    class flash_scoreboard;
        t_flash_phase phase;
        logic         wel;
        logic [2:0]   xfer_cnt;
        logic [23:0]  rd_addr;
        logic [23:0]  jedec;
        logic [7:0]   mem [ARRAY_BYTES];
        bit           loaded [ARRAY_BYTES];
        t_flash_resp  expected_q [$];
        int           errors;

        function new();
            phase    = ST_IDLE;
            wel      = 1'b0;
            xfer_cnt = '0;
            rd_addr  = '0;
            jedec    = sfcr_pkg::JEDEC_RESET;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] shift_byte(logic [7:0] v);
            logic [7:0]  d;
            logic [17:0] a;
            d = 8'h00;
            if (phase == ST_DEEP) begin
                if (v == sfcr_pkg::CMD_RES)
                    phase = ST_IDLE;
                return d;
            end
            case (phase)
                ST_CMD: begin
                    case (v)
                        sfcr_pkg::CMD_WREN:      begin wel = 1'b1; phase = ST_IDLE; end
                        sfcr_pkg::CMD_WRDI:      begin wel = 1'b0; phase = ST_IDLE; end
                        sfcr_pkg::CMD_RDID:      phase = ST_ID;
                        sfcr_pkg::CMD_READ:      phase = ST_ADDR;
                        sfcr_pkg::CMD_FAST_READ: phase = ST_ADDR_FAST;
                        sfcr_pkg::CMD_DP:        phase = ST_DEEP;
                        default: ;
                    endcase
                end
                ST_ADDR, ST_ADDR_FAST: begin
                    if (xfer_cnt == 3'd1)
                        rd_addr = {16'h0000, v};
                    else if (xfer_cnt == 3'd2 || xfer_cnt == 3'd3)
                        rd_addr = {rd_addr[15:0], v};
                    if (xfer_cnt == 3'd3)
                        phase = (phase == ST_ADDR) ? ST_STREAM : ST_DUMMY;
                end
                ST_DUMMY: phase = ST_STREAM;
                ST_STREAM: begin
                    a = rd_addr[17:0];
                    d = mem[a];
                    a = a + 18'd1;
                    rd_addr = {6'h00, a};
                end
                ST_ID: begin
                    if (xfer_cnt == 3'd1) begin
                        d = jedec[23:16];
                    end else if (xfer_cnt == 3'd2) begin
                        d = jedec[15:8];
                    end else if (xfer_cnt == 3'd3) begin
                        d = jedec[7:0];
                        phase = ST_IDLE;
                    end
                end
                default: ;
            endcase
            if (xfer_cnt != sfcr_pkg::COUNT_MAX)
                xfer_cnt = xfer_cnt + 3'd1;
            return d;
        endfunction

        function void note_word(logic [1:0] k, logic [7:0] b, logic [17:0] a);
            t_flash_resp r;
            r.read_data = 8'h00;
            case (k)
                sfcr_pkg::KIND_XFER: r.read_data = shift_byte(b);
                sfcr_pkg::KIND_CS: begin
                    if (phase != ST_DEEP)
                        phase = ST_CMD;
                    xfer_cnt = '0;
                end
                sfcr_pkg::KIND_LOAD: begin
                    mem[a]    = b;
                    loaded[a] = 1'b1;
                end
                default: ;
            endcase
            r.write_enabled = wel;
            r.asleep        = (phase == ST_DEEP);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [7:0] data, logic wel_o, logic dp_o);
            t_flash_resp want;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: read_data=%0h", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.read_data) begin
                $error("read_data: expected %0h, actual %0h", want.read_data, data);
                errors++;
            end
            if (wel_o !== want.write_enabled) begin
                $error("write_enabled: expected %0b, actual %0b", want.write_enabled, wel_o);
                errors++;
            end
            if (dp_o !== want.asleep) begin
                $error("asleep: expected %0b, actual %0b", want.asleep, dp_o);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_kind         = sfcr_pkg::KIND_XFER;
    logic [7:0]  i_byte_value   = 8'h00;
    logic [17:0] i_load_address = '0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [23:0] i_cfg_wr_data  = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic        o_write_enabled;
    logic        o_asleep;

    flash_scoreboard sb;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          hold_request  = 1'b0;
    int          words_sent    = 0;
    int          cycle_count   = 0;
    logic [17:0] load_bases [$];
    logic [7:0]  known_cmds [7] = '{sfcr_pkg::CMD_WREN, sfcr_pkg::CMD_WRDI,
                                    sfcr_pkg::CMD_RDID, sfcr_pkg::CMD_READ,
                                    sfcr_pkg::CMD_FAST_READ, sfcr_pkg::CMD_DP,
                                    sfcr_pkg::CMD_RES};

    spi_flash_command_responder #(
        .ARRAY_BYTES(ARRAY_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_byte_value   (i_byte_value),
        .i_load_address (i_load_address),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_write_enabled(o_write_enabled),
        .o_asleep       (o_asleep)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall; a hold request parks it for a long stretch
    always begin
        @(posedge i_clk);
        if (hold_request) begin
            hold_request = 1'b0;
            i_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // outputs are stable at the falling edge; the word is taken at the next rise
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_read_data, o_write_enabled, o_asleep);
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [17:0] rnd_addr();
        return 18'($urandom_range(ARRAY_BYTES - 1));
    endfunction

    task automatic push_word(input logic [1:0] k, input logic [7:0] b, input logic [17:0] a);
        bit acc;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= k;
        i_byte_value   <= b;
        i_load_address <= a;
        acc = 1'b0;
        while (!acc) begin
            @(negedge i_clk);
            acc = !o_stall;
            @(posedge i_clk);
        end
        sb.note_word(k, b, a);
        words_sent++;
    endtask

    // a streaming read never touches an array byte that was not loaded first
    task automatic send_word(input logic [1:0] k, input logic [7:0] b, input logic [17:0] a);
        if (k == sfcr_pkg::KIND_XFER && sb.phase == ST_STREAM && !sb.loaded[sb.rd_addr[17:0]])
            push_word(sfcr_pkg::KIND_LOAD, rnd_byte(), sb.rd_addr[17:0]);
        push_word(k, b, a);
    endtask

    task automatic send_xfer(input logic [7:0] b);
        send_word(sfcr_pkg::KIND_XFER, b, rnd_addr());
    endtask

    task automatic send_cs();
        send_word(sfcr_pkg::KIND_CS, rnd_byte(), rnd_addr());
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_jedec(input logic [23:0] id);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.jedec = id;
    endtask

    task automatic run_random(input int n);
        int          stop_at;
        int          r;
        int          len;
        logic [7:0]  cmd;
        logic [17:0] base;
        logic [5:0]  top;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            if (sb.phase == ST_DEEP && $urandom_range(3) != 0)
                send_xfer(sfcr_pkg::CMD_RES);
            r = $urandom_range(99);
            if (r < 22) begin
                cmd = $urandom_range(1) ? sfcr_pkg::CMD_READ : sfcr_pkg::CMD_FAST_READ;
                if (load_bases.size() != 0 && $urandom_range(3) != 0)
                    base = load_bases[$urandom_range(load_bases.size() - 1)]
                           + 18'($urandom_range(7));
                else
                    base = rnd_addr();
                top = 6'($urandom_range(63));
                send_cs();
                send_xfer(cmd);
                send_xfer({top, base[17:16]});
                send_xfer(base[15:8]);
                send_xfer(base[7:0]);
                if (cmd == sfcr_pkg::CMD_FAST_READ)
                    send_xfer(rnd_byte());
                repeat ($urandom_range(16, 1)) send_xfer(rnd_byte());
            end else if (r < 32) begin
                base = ($urandom_range(4) == 0) ? 18'(ARRAY_BYTES - $urandom_range(8, 1))
                                                : rnd_addr();
                len = $urandom_range(12, 2);
                for (int i = 0; i < len; i++)
                    send_word(sfcr_pkg::KIND_LOAD, rnd_byte(), base + 18'(i));
                load_bases.push_back(base);
                if (load_bases.size() > 16)
                    void'(load_bases.pop_front());
            end else if (r < 44) begin
                send_cs();
                send_xfer(sfcr_pkg::CMD_RDID);
                repeat ($urandom_range(5, 1)) send_xfer(rnd_byte());
            end else if (r < 54) begin
                send_cs();
                send_xfer($urandom_range(1) ? sfcr_pkg::CMD_WREN : sfcr_pkg::CMD_WRDI);
                repeat ($urandom_range(2)) send_xfer(rnd_byte());
            end else if (r < 62) begin
                send_cs();
                send_xfer(sfcr_pkg::CMD_DP);
                repeat ($urandom_range(3))
                    send_word(2'($urandom_range(3)), rnd_byte(), rnd_addr());
                if ($urandom_range(1))
                    send_cs();
                send_xfer(sfcr_pkg::CMD_RES);
            end else if (r < 76) begin
                // command arrives late, after stray bytes
                send_cs();
                repeat ($urandom_range(3, 1)) send_xfer(rnd_byte());
                send_xfer(known_cmds[$urandom_range(6)]);
                repeat ($urandom_range(5)) send_xfer(rnd_byte());
            end else begin
                repeat ($urandom_range(4, 1))
                    send_word(2'($urandom_range(3)), rnd_byte(), rnd_addr());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_xfer(8'h00);
        send_word(KIND_RSVD, 8'hFF, 18'h3FFFF);
        send_word(sfcr_pkg::KIND_LOAD, 8'h00, 18'h00000);
        send_word(sfcr_pkg::KIND_LOAD, 8'hFF, 18'h3FFFF);
        send_cs();
        send_xfer(sfcr_pkg::CMD_RDID);
        repeat (3) send_xfer(8'hFF);
        send_cs();
        send_xfer(sfcr_pkg::CMD_WREN);
        send_cs();
        send_xfer(sfcr_pkg::CMD_WRDI);
        send_cs();
        send_xfer(sfcr_pkg::CMD_READ);
        repeat (3) send_xfer(8'hFF);
        repeat (2) send_xfer(8'h00);
        send_cs();
        send_xfer(8'h00);
        send_xfer(sfcr_pkg::CMD_RDID);
        repeat (2) send_xfer(8'h55);
        send_cs();
        send_xfer(sfcr_pkg::CMD_DP);
        send_cs();
        send_xfer(sfcr_pkg::CMD_RES);

        write_jedec(24'h000000);
        run_random(450);

        write_jedec(24'hFFFFFF);
        send_idle_pct = 85;
        run_random(450);

        write_jedec(24'($urandom_range(24'hFFFFFF)));
        send_idle_pct = 0;
        stall_pct     = 85;
        run_random(450);

        write_jedec(sfcr_pkg::JEDEC_RESET);
        send_idle_pct = 30;
        stall_pct     = 30;
        run_random(450);

        // long receiver hold-off with the sender pushing at full rate
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        run_random(60);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
